[src/assert_macros.svh]
// Assertion macros for the port-level checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define HBS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hbs assertion failed");

// Clocked assertion that also holds through reset.
`define HBS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hbs assertion failed");

`endif

[src/hbs_pkg.sv]
// Shared types and constants for the heightmap bump shading unit.
// No dependencies.
`default_nettype none
package hbs_pkg;

  // divider datapath widths
  localparam int DIV_RW = 24;
  localparam int DIV_LW = 29;
  localparam int DIV_CW = 5;

  localparam logic [DIV_CW-1:0] ITER_GRAD  = 5'd29;
  localparam logic [DIV_CW-1:0] ITER_NORM  = 5'd16;
  localparam logic [DIV_CW-1:0] ITER_NORMY = 5'd17;

  localparam logic [22:0]        GRAD_SAT = 23'h7F_FFFF;
  localparam logic signed [35:0] B_MAX    = 36'sh0_4000_0000;
  localparam logic [15:0]        BRIGHT_ONE = 16'h8000;

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_SHADE = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIV_RW-1:0] rem0;
    logic [DIV_LW-1:0] lo;
    logic [DIV_RW-1:0] den;
    logic [DIV_CW-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_LW-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_GRAD_X, ST_GRAD_Z, ST_SQUARE, ST_SQRT,
    ST_NORM_X, ST_NORM_Y, ST_NORM_Z, ST_DOT, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    REG_LIGHT_X, REG_LIGHT_Y, REG_LIGHT_Z, REG_SPACING,
    REG_WRAP_EDGES, REG_MAP_WIDTH, REG_MAP_HEIGHT
  } reg_idx_t;

endpackage
`default_nettype wire

[src/heightmap_bump_shading_unit.sv]
// Heightmap bump shading unit: a store item (mode 0) writes one Q4.12 height
// sample. A shade item (mode 1) reads the four neighbours from the height
// memory one per cycle, forms Q8.16 gradients with a shared divider that
// yields one quotient bit per cycle, squares them, runs a 24-step integer
// square root, normalizes with three more divider passes and accumulates
// the light dot product on one multiplier. Every divider pass is started
// with a start request and ends on the divider's done strobe. Results sit
// in an output register, so a finished result may wait on out_stall while
// the next transfer is already accepted. Height memory content is undefined
// until written; it needs no clearing after reset.
// Depends on hbs_pkg and hbs_div.
`default_nettype none
module heightmap_bump_shading_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [7:0]         in_col,
  input  logic [7:0]         in_row,
  input  logic signed [15:0] in_height,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_brightness,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import hbs_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] WIDTH_A = AW'(MAX_WIDTH);
  localparam logic [31:0]   MAXW_C  = 32'(MAX_WIDTH);
  localparam logic [31:0]   MAXH_C  = 32'(MAX_HEIGHT);

  // ---------------- configuration registers ----------------
  logic signed [15:0] light_x_r, light_y_r, light_z_r;
  logic [15:0]        spacing_r;
  logic               wrap_r;
  logic [8:0]         map_width_r, map_height_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_x_r    <= 16'sd0;
      light_y_r    <= 16'sd16384;
      light_z_r    <= 16'sd0;
      spacing_r    <= 16'd256;
      wrap_r       <= 1'b0;
      map_width_r  <= 9'd256;
      map_height_r <= 9'd256;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LIGHT_X:    light_x_r    <= pwdata[15:0];
        REG_LIGHT_Y:    light_y_r    <= pwdata[15:0];
        REG_LIGHT_Z:    light_z_r    <= pwdata[15:0];
        REG_SPACING:    spacing_r    <= pwdata[15:0];
        REG_WRAP_EDGES: wrap_r       <= pwdata[0];
        REG_MAP_WIDTH:  map_width_r  <= pwdata[8:0];
        REG_MAP_HEIGHT: map_height_r <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LIGHT_X:    prdata = {16'b0, light_x_r};
      REG_LIGHT_Y:    prdata = {16'b0, light_y_r};
      REG_LIGHT_Z:    prdata = {16'b0, light_z_r};
      REG_SPACING:    prdata = {16'b0, spacing_r};
      REG_WRAP_EDGES: prdata = {31'b0, wrap_r};
      REG_MAP_WIDTH:  prdata = {23'b0, map_width_r};
      REG_MAP_HEIGHT: prdata = {23'b0, map_height_r};
      default:        prdata = '0;
    endcase
  end

  // effective map size and spacing: zero means one, clamp to the store
  logic [8:0]  mw_raw, mh_raw, mw, mh;
  logic [15:0] sp;
  always_comb begin
    mw_raw = (map_width_r == 9'd0) ? 9'd1 : map_width_r;
    mh_raw = (map_height_r == 9'd0) ? 9'd1 : map_height_r;
    mw     = (32'(mw_raw) > MAXW_C) ? MAXW_C[8:0] : mw_raw;
    mh     = (32'(mh_raw) > MAXH_C) ? MAXH_C[8:0] : mh_raw;
    sp     = (spacing_r == 16'd0) ? 16'd1 : spacing_r;
  end

  // ---------------- state and datapath registers ----------------
  state_t             state_r, state_nxt;
  logic               issued_r, issued_nxt;
  logic [2:0]         rd_cnt_r, rd_cnt_nxt;
  logic [1:0]         step_r, step_nxt;
  logic [7:0]         x_r, x_nxt, y_r, y_nxt;
  logic signed [15:0] smp_r [4];
  logic [22:0]        gx_mag_r, gx_mag_nxt, gz_mag_r, gz_mag_nxt;
  logic               gx_neg_r, gx_neg_nxt, gz_neg_r, gz_neg_nxt;
  logic [45:0]        sq_x_r, sq_x_nxt, sq_z_r, sq_z_nxt;
  logic [47:0]        sv_r, sv_nxt, sres_r, sres_nxt, sbit_r, sbit_nxt;
  logic [16:0]        nx_mag_r, nx_mag_nxt, ny_mag_r, ny_mag_nxt, nz_mag_r, nz_mag_nxt;
  logic signed [33:0] prod_r, prod_nxt;
  logic signed [35:0] acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        out_bright_r, out_bright_nxt;

  // ---------------- height memory ----------------
  logic [15:0]   mem [DEPTH];
  logic [15:0]   rd_q_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= in_height;
    if (mem_re) rd_q_r <= mem[raddr];
  end

  logic in_acc;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;

  // out-of-range writes are dropped
  assign mem_we = in_acc & (in_mode == MODE_STORE) &
                  (32'(in_col) < MAXW_C) & (32'(in_row) < MAXH_C);
  assign waddr  = AW'(in_row) * WIDTH_A + AW'(in_col);

  // neighbour coordinates; interior case equals x-1/x+1
  logic [7:0] xm1, xp1, ym1, yp1, rx, ry;
  always_comb begin
    xm1 = (x_r == 8'd0) ? 8'(mw - 9'd1) : x_r - 8'd1;
    xp1 = ({1'b0, x_r} == mw - 9'd1) ? 8'd0 : x_r + 8'd1;
    ym1 = (y_r == 8'd0) ? 8'(mh - 9'd1) : y_r - 8'd1;
    yp1 = ({1'b0, y_r} == mh - 9'd1) ? 8'd0 : y_r + 8'd1;
    case (rd_cnt_r[1:0])
      2'd0:    begin rx = xm1; ry = y_r; end
      2'd1:    begin rx = xp1; ry = y_r; end
      2'd2:    begin rx = x_r; ry = ym1; end
      default: begin rx = x_r; ry = yp1; end
    endcase
  end
  assign raddr  = AW'(ry) * WIDTH_A + AW'(rx);
  assign mem_re = (state_r == ST_READ) && (rd_cnt_r < 3'd4);

  // accept-time classification of a shade request
  logic outside, on_border;
  always_comb begin
    outside   = ({1'b0, in_col} >= mw) || ({1'b0, in_row} >= mh);
    on_border = (in_col == 8'd0) || (in_row == 8'd0) ||
                ({1'b0, in_col} == mw - 9'd1) || ({1'b0, in_row} == mh - 9'd1);
  end

  // central differences and their magnitudes
  logic signed [16:0] dx, dz, dsel;
  logic [15:0]        dmag;
  always_comb begin
    dx   = 17'(smp_r[0]) - 17'(smp_r[1]);
    dz   = 17'(smp_r[2]) - 17'(smp_r[3]);
    dsel = (state_r == ST_GRAD_X) ? dx : dz;
    dmag = dsel[16] ? 16'(-dsel) : dsel[15:0];
  end

  // shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;
  hbs_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  logic [22:0] gsat;
  assign gsat = (div_rsp.quo > 29'(GRAD_SAT)) ? GRAD_SAT : div_rsp.quo[22:0];

  // squarer
  logic [22:0] sq_op;
  logic [45:0] sq_prod;
  assign sq_op   = (step_r == 2'd0) ? gx_mag_r : gz_mag_r;
  assign sq_prod = 46'(sq_op) * 46'(sq_op);

  // square root step
  logic [47:0] s_trial;
  logic        s_ge;
  assign s_trial = sres_r + sbit_r;
  assign s_ge    = (sv_r >= s_trial);

  // dot product multiplier
  logic signed [17:0] nxs, nys, nzs, mul_n;
  logic signed [15:0] mul_l;
  logic signed [33:0] mul_p;
  always_comb begin
    nxs = gx_neg_r ? -$signed({1'b0, nx_mag_r}) : $signed({1'b0, nx_mag_r});
    nys = $signed({1'b0, ny_mag_r});
    nzs = gz_neg_r ? -$signed({1'b0, nz_mag_r}) : $signed({1'b0, nz_mag_r});
    case (step_r)
      2'd0:    begin mul_l = light_x_r; mul_n = nxs; end
      2'd1:    begin mul_l = light_y_r; mul_n = nys; end
      default: begin mul_l = light_z_r; mul_n = nzs; end
    endcase
    mul_p = 34'(mul_l) * 34'(mul_n);
  end

  // clamp to 0..1.0 and drop to Q1.15
  logic [15:0] bright;
  always_comb begin
    if (acc_r[35])           bright = 16'd0;
    else if (acc_r > B_MAX)  bright = BRIGHT_ONE;
    else                     bright = acc_r[30:15];
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt      = state_r;
    issued_nxt     = issued_r;
    rd_cnt_nxt     = rd_cnt_r;
    step_nxt       = step_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    gx_mag_nxt     = gx_mag_r;
    gz_mag_nxt     = gz_mag_r;
    gx_neg_nxt     = gx_neg_r;
    gz_neg_nxt     = gz_neg_r;
    sq_x_nxt       = sq_x_r;
    sq_z_nxt       = sq_z_r;
    sv_nxt         = sv_r;
    sres_nxt       = sres_r;
    sbit_nxt       = sbit_r;
    nx_mag_nxt     = nx_mag_r;
    ny_mag_nxt     = ny_mag_r;
    nz_mag_nxt     = nz_mag_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_bright_nxt = out_bright_r;
    div_req        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_mode == MODE_SHADE) begin
          x_nxt      = in_col;
          y_nxt      = in_row;
          gx_mag_nxt = '0;
          gz_mag_nxt = '0;
          gx_neg_nxt = 1'b0;
          gz_neg_nxt = 1'b0;
          rd_cnt_nxt = '0;
          step_nxt   = '0;
          if (outside) begin
            acc_nxt   = '0;
            state_nxt = ST_DONE;
          end else if (!wrap_r && on_border) begin
            state_nxt = ST_SQUARE;   // flat normal
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        rd_cnt_nxt = rd_cnt_r + 3'd1;
        if (rd_cnt_r == 3'd4) state_nxt = ST_GRAD_X;
      end
      ST_GRAD_X, ST_GRAD_Z: begin
        div_req.rem0  = '0;
        div_req.lo    = 29'({dmag, 12'b0});
        div_req.den   = 24'(sp);
        div_req.iters = ITER_GRAD;
        if (!issued_r) begin
          div_req.start = 1'b1;
          issued_nxt    = 1'b1;
        end else if (div_rsp.done) begin
          issued_nxt = 1'b0;
          if (state_r == ST_GRAD_X) begin
            gx_mag_nxt = gsat;
            gx_neg_nxt = dsel[16];
            state_nxt  = ST_GRAD_Z;
          end else begin
            gz_mag_nxt = gsat;
            gz_neg_nxt = dsel[16];
            state_nxt  = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        step_nxt = step_r + 2'd1;
        case (step_r)
          2'd0: sq_x_nxt = sq_prod;
          2'd1: sq_z_nxt = sq_prod;
          default: begin
            sv_nxt    = 48'(sq_x_r) + 48'(sq_z_r) + 48'h1_0000_0000;
            sres_nxt  = '0;
            sbit_nxt  = 48'h4000_0000_0000;
            step_nxt  = '0;
            state_nxt = ST_SQRT;
          end
        endcase
      end
      ST_SQRT: begin
        if (s_ge) begin
          sv_nxt   = sv_r - s_trial;
          sres_nxt = (sres_r >> 1) + sbit_r;
        end else begin
          sres_nxt = sres_r >> 1;
        end
        sbit_nxt = sbit_r >> 2;
        if (sbit_r == 48'd1) state_nxt = ST_NORM_X;
      end
      ST_NORM_X, ST_NORM_Y, ST_NORM_Z: begin
        div_req.lo  = '0;
        div_req.den = sres_r[23:0];   // length, always >= 1.0
        case (state_r)
          ST_NORM_X: begin
            div_req.rem0  = 24'(gx_mag_r);
            div_req.iters = ITER_NORM;
          end
          ST_NORM_Y: begin
            div_req.rem0  = 24'h00_8000;  // 2^32 pre-shifted by 17
            div_req.iters = ITER_NORMY;
          end
          default: begin
            div_req.rem0  = 24'(gz_mag_r);
            div_req.iters = ITER_NORM;
          end
        endcase
        if (!issued_r) begin
          div_req.start = 1'b1;
          issued_nxt    = 1'b1;
        end else if (div_rsp.done) begin
          issued_nxt = 1'b0;
          case (state_r)
            ST_NORM_X: begin nx_mag_nxt = div_rsp.quo[16:0]; state_nxt = ST_NORM_Y; end
            ST_NORM_Y: begin ny_mag_nxt = div_rsp.quo[16:0]; state_nxt = ST_NORM_Z; end
            default:   begin nz_mag_nxt = div_rsp.quo[16:0]; state_nxt = ST_DOT; end
          endcase
        end
      end
      ST_DOT: begin
        step_nxt = step_r + 2'd1;
        prod_nxt = mul_p;
        if (step_r == 2'd0) acc_nxt = '0;
        else                acc_nxt = acc_r + 36'(prod_r);
        if (step_r == 2'd3) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_bright_nxt = bright;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      rd_cnt_r    <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    gx_mag_r     <= gx_mag_nxt;
    gz_mag_r     <= gz_mag_nxt;
    gx_neg_r     <= gx_neg_nxt;
    gz_neg_r     <= gz_neg_nxt;
    sq_x_r       <= sq_x_nxt;
    sq_z_r       <= sq_z_nxt;
    sv_r         <= sv_nxt;
    sres_r       <= sres_nxt;
    sbit_r       <= sbit_nxt;
    nx_mag_r     <= nx_mag_nxt;
    ny_mag_r     <= ny_mag_nxt;
    nz_mag_r     <= nz_mag_nxt;
    prod_r       <= prod_nxt;
    acc_r        <= acc_nxt;
    out_bright_r <= out_bright_nxt;
    // memory data of read k lands while rd_cnt is k+1
    if (state_r == ST_READ && rd_cnt_r != 3'd0)
      smp_r[2'(rd_cnt_r - 3'd1)] <= rd_q_r;
  end

  assign out_valid      = out_valid_r;
  assign out_brightness = out_bright_r;

endmodule
`default_nettype wire

[src/hbs_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on hbs_pkg.
`default_nettype none
module hbs_div (
  input  logic             clk,
  input  logic             rst_n,
  input  hbs_pkg::div_req_t req,
  output hbs_pkg::div_rsp_t rsp
);
  import hbs_pkg::*;

  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_RW-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [DIV_LW-1:0] lo_r, lo_nxt, q_r, q_nxt;
  logic [DIV_RW:0]   trial, diff;
  logic              ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    trial    = {rem_r, lo_r[DIV_LW-1]};
    diff     = trial - {1'b0, den_r};
    ge       = (trial >= {1'b0, den_r});
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.iters;
      rem_nxt  = req.rem0;
      den_nxt  = req.den;
      lo_nxt   = req.lo;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_RW-1:0] : trial[DIV_RW-1:0];
      lo_nxt  = {lo_r[DIV_LW-2:0], 1'b0};
      q_nxt   = {q_r[DIV_LW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = q_r;

endmodule
`default_nettype wire

[src/hbs_checker.sv]
// Port-level checks for the heightmap bump shading unit, bound to the top.
// Depends on hbs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module hbs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_mode,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_brightness,
  input wire logic        pready
);
  import hbs_pkg::*;

  `HBS_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_brightness))
  `HBS_ASSERT(a_bright_max, clk, rst_n, out_valid |-> out_brightness <= 16'd32768)
  `HBS_ASSERT(a_shade_busy, clk, rst_n, in_valid && !in_stall && in_mode == MODE_SHADE |=> in_stall)
  `HBS_ASSERT_ALWAYS(a_pready, clk, pready)

endmodule

bind heightmap_bump_shading_unit hbs_checker u_hbs_checker (.*);
`default_nettype wire

[test/shade_checker.sv]
// Checker for the heightmap bump shading unit: mirrors the register file and
// height memory, predicts brightness per shade transfer and compares results.
// Depends on hbs_pkg.
`timescale 1ns / 100ps
module shade_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_mode,
  input  logic [7:0]         in_col,
  input  logic [7:0]         in_row,
  input  logic signed [15:0] in_height,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        out_brightness,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending_count
);
  import hbs_pkg::*;

  logic signed [15:0] heights [0:65535];
  logic signed [15:0] lx, ly, lz;
  logic [15:0] spc;
  logic        wrap;
  logic [8:0]  mw_reg, mh_reg;
  logic [15:0] bright_q[$];

  function automatic longint grad_q16(longint d, longint sp);
    longint g;
    g = (d * 4096) / sp;
    if (g > 8388607) g = 8388607;
    if (g < -8388607) g = -8388607;
    return g;
  endfunction

  function automatic longint isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic logic [15:0] shade_pixel(int x, int y);
    int mw, mh, x1, x2, y1, y2;
    longint sp, gx, gz, len, nx, ny, nz, b;
    mw = (mw_reg == 0) ? 1 : ((mw_reg > 256) ? 256 : int'(mw_reg));
    mh = (mh_reg == 0) ? 1 : ((mh_reg > 256) ? 256 : int'(mh_reg));
    sp = (spc == 0) ? 1 : longint'(spc);
    gx = 0;
    gz = 0;
    if (x >= mw || y >= mh) return 16'd0;
    if (wrap) begin
      x1 = (x == 0) ? mw - 1 : x - 1;
      x2 = (x == mw - 1) ? 0 : x + 1;
      y1 = (y == 0) ? mh - 1 : y - 1;
      y2 = (y == mh - 1) ? 0 : y + 1;
      gx = grad_q16(longint'(heights[y*256+x1]) - heights[y*256+x2], sp);
      gz = grad_q16(longint'(heights[y1*256+x]) - heights[y2*256+x], sp);
    end else if (!(x == 0 || y == 0 || x == mw - 1 || y == mh - 1)) begin
      gx = grad_q16(longint'(heights[y*256+x-1]) - heights[y*256+x+1], sp);
      gz = grad_q16(longint'(heights[(y-1)*256+x]) - heights[(y+1)*256+x], sp);
    end
    len = isqrt(gx*gx + (64'd1 << 32) + gz*gz);
    nx = (gx * 65536) / len;
    ny = (64'sd1 <<< 32) / len;
    nz = (gz * 65536) / len;
    b = longint'(lx) * nx + longint'(ly) * ny + longint'(lz) * nz;
    if (b < 0) b = 0;
    if (b > (64'sd1 <<< 30)) b = 64'sd1 <<< 30;
    return b[30:15];
  endfunction

  assign pending_count = bright_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      lx <= 16'sd0; ly <= 16'sd16384; lz <= 16'sd0; spc <= 16'd256; wrap <= 1'b0;
      mw_reg <= 9'd256; mh_reg <= 9'd256;
      fail_count <= 0;
      bright_q.delete();
    end else begin
      // register writes land at the access phase
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_LIGHT_X:    lx <= pwdata[15:0];
          REG_LIGHT_Y:    ly <= pwdata[15:0];
          REG_LIGHT_Z:    lz <= pwdata[15:0];
          REG_SPACING:    spc <= pwdata[15:0];
          REG_WRAP_EDGES: wrap <= pwdata[0];
          REG_MAP_WIDTH:  mw_reg <= pwdata[8:0];
          REG_MAP_HEIGHT: mh_reg <= pwdata[8:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_mode == MODE_STORE) heights[{in_row, in_col}] = in_height;
        else bright_q.push_back(shade_pixel(int'(in_col), int'(in_row)));
      end
      if (out_valid && !out_stall) begin
        if (bright_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d",
                   $time, out_brightness);
          fail_count <= fail_count + 1;
        end else begin
          if (out_brightness !== bright_q[0]) begin
            $display("%0t: brightness mismatch, expected %0d, actual %0d",
                     $time, bright_q[0], out_brightness);
            fail_count <= fail_count + 1;
          end
          void'(bright_q.pop_front());
        end
      end
    end
  end
endmodule

[test/testbench.sv]
// Top of the shading unit testbench: clock, reset, register phases, stimulus
// with bursty sender and stalling receiver, and the final verdict.
// Depends on hbs_pkg, heightmap_bump_shading_unit and shade_checker.
`timescale 1ns / 100ps
module testbench;
  import hbs_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_mode = 0;
  logic in_stall;
  logic [7:0] in_col = 0, in_row = 0;
  logic signed [15:0] in_height = 0;
  logic out_valid, out_stall = 0;
  logic [15:0] out_brightness;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  int fail_count, pending_count;
  int unsigned cycle_count = 0;
  bit written [0:65535];
  int cur_w, cur_h;
  int stall_mode = 0;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  heightmap_bump_shading_unit u_dut (.*);

  shade_checker u_chk (.*);

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stalls in a pattern that changes mode now and then
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // one transfer on the input channel, then an optional gap
  task automatic send_item(logic m, int c, int r, logic [15:0] h);
    in_valid <= 1; in_mode <= m; in_col <= 8'(c); in_row <= 8'(r); in_height <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (m == MODE_STORE) written[{r[7:0], c[7:0]}] = 1;
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic store(int c, int r, logic [15:0] h);
    send_item(MODE_STORE, c, r, h);
  endtask

  // shade only where every neighbor the block may read is already written
  task automatic shade_safe(int c, int r);
    int mw, mh, ok;
    mw = cur_w; mh = cur_h;
    ok = 1;
    if (c < mw && r < mh) begin
      for (int dx = -1; dx <= 1; dx++)
        for (int dy = -1; dy <= 1; dy++)
          if ((dx == 0) != (dy == 0)) begin
            if (!written[{8'(((r + dy) % mh + mh) % mh), 8'(((c + dx) % mw + mw) % mw)}])
              ok = 0;
          end
    end
    if (ok) send_item(MODE_SHADE, c, r, 16'($urandom));
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic fill_map(int w, int h, int amp);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        store(c, r, (amp == 0) ? 16'($urandom) : 16'($urandom_range(0, amp)));
  endtask

  task automatic set_map(int w, int h, bit wr, logic [15:0] sp,
                         logic [15:0] x, logic [15:0] y, logic [15:0] z);
    reg_write(REG_MAP_WIDTH, w);
    reg_write(REG_MAP_HEIGHT, h);
    reg_write(REG_WRAP_EDGES, 32'(wr));
    reg_write(REG_SPACING, 32'(sp));
    reg_write(REG_LIGHT_X, 32'(x));
    reg_write(REG_LIGHT_Y, 32'(y));
    reg_write(REG_LIGHT_Z, 32'(z));
    cur_w = (w == 0) ? 1 : (w > 256 ? 256 : w);
    cur_h = (h == 0) ? 1 : (h > 256 ? 256 : h);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: small map, extreme heights, defaults first
    set_map(4, 4, 1'b0, 16'd256, 16'd0, 16'd16384, 16'd0);
    store(0, 0, 16'h7FFF); store(1, 0, 16'h8000); store(2, 0, 16'h0000);
    store(3, 0, 16'hFFFF);
    fill_map(4, 4, 0);
    store(255, 255, 16'h1234);              // outside the map in use
    shade_safe(0, 0);                       // flat border
    shade_safe(1, 1);
    shade_safe(2, 2);
    shade_safe(3, 3);
    shade_safe(200, 1);                     // outside the map
    shade_safe(1, 255);
    drain();
    // extreme registers: wrap, zero spacing, zero and oversized dimensions
    set_map(0, 511, 1'b1, 16'd0, 16'h7FFF, 16'h8000, 16'h7FFF);
    shade_safe(0, 0);
    drain();
    set_map(4, 4, 1'b1, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000);
    shade_safe(0, 0); shade_safe(3, 2); shade_safe(1, 2);
    drain();

    // random phases: well-formed fill then shading
    for (int ph = 0; ph < 8; ph++) begin
      int w, h, n;
      w = (ph == 7) ? 2 : $urandom_range(2, 12);
      h = $urandom_range(2, 12);
      set_map(w, h, 1'($urandom_range(0, 1)),
              (ph % 3 == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(1, 65535)),
              16'($urandom), 16'($urandom), 16'($urandom));
      fill_map(w, h, (ph % 2) ? 0 : 512);
      n = 35;
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(0, 9))
          0: shade_safe($urandom_range(0, 255), $urandom_range(0, 255));
          1: store($urandom_range(0, 255), $urandom_range(0, 255), 16'($urandom));
          2: store($urandom_range(0, w - 1), $urandom_range(0, h - 1), 16'($urandom));
          default: shade_safe($urandom_range(0, w - 1), $urandom_range(0, h - 1));
        endcase
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
